[rtl/core/mlemq_pkg.sv]
// Shared types, sizes and codes of the lower envelope minimum query unit.
package mlemq_pkg;

  localparam int MAX_LINES = 1024;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int SLOPE_W   = 24;
  localparam int ICPT_W    = 32;
  localparam int X_W       = 24;
  localparam int VAL_W     = 48;
  // widest cross product: (33-bit intercept difference) * (25-bit slope difference)
  localparam int PROD_W    = (ICPT_W + 1) + (SLOPE_W + 1);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINES);

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_ANSWER = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                       command;
    logic signed [SLOPE_W-1:0]  slope;
    logic signed [ICPT_W-1:0]   intercept;
    logic signed [X_W-1:0]      query_x;
  } in_item_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VAL_W-1:0]    min_value;
    logic        [CNT_W-1:0]    hull_size;
  } out_item_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0]  slope;
    logic signed [ICPT_W-1:0]   intercept;
  } line_t;

  typedef struct packed {
    logic                       wr_en;
    logic        [IDX_W-1:0]    wr_addr;
    line_t                      wr_line;
    logic        [IDX_W-1:0]    rd_addr_a;
    logic        [IDX_W-1:0]    rd_addr_b;
  } store_req_t;

endpackage

[rtl/core/monotone_lower_envelope_min_query_unit.sv]
// Top level: convex hull trick stack with pointer-walk minimum queries.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   input   | in        | in_valid_i / in_stall_o | command, slope, intercept, x
//   output  | out       | out_valid_o/out_stall_i | status, min_value, hull_size
//
// Adds pop lines in read-multiply-compare rounds and then push, or push at the read when at
// most one line remains. Queries step the pointer likewise, or end at the read on an empty hull.
// Each round trip is read of the store, a shared pair of multipliers, then a compare.
// Reset empties the hull and zeroes the query pointer; the store is not cleared.
// One item is in work at a time; a finished result waits in the output register while the
// next item is taken, and a stalled output holds the block only when a second result is ready.
module monotone_lower_envelope_min_query_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mlemq_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mlemq_pkg::out_item_t  out_item_o
);
  import mlemq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_CMP  = 5'b01000,
    S_WAIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] hull_len_q, hull_len_d;
  logic [IDX_W-1:0] qp_q, qp_d;
  logic signed [PROD_W-1:0] prod0_q, prod0_d, prod1_q, prod1_d;
  logic signed [ICPT_W-1:0] ica_q, ica_d, icb_q, icb_d;
  out_item_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  store_req_t req;
  line_t rd_a, rd_b;

  logic out_free;
  logic push;
  logic fin;
  out_item_t fin_item;
  logic [IDX_W-1:0] clamp_ptr;
  logic signed [ICPT_W:0] op_a0, op_a1;
  logic signed [SLOPE_W:0] op_c0, op_c1;
  logic signed [PROD_W-1:0] val_a, val_b;
  logic [CNT_W-1:0] ptr_next;

  mlemq_store u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // clamp the saved pointer to the top line
  assign clamp_ptr = ({1'b0, qp_q} >= hull_len_q) ? IDX_W'(hull_len_q - 1'b1) : qp_q;

  assign val_a = prod0_q + {{(PROD_W-ICPT_W){ica_q[ICPT_W-1]}}, ica_q};
  assign val_b = prod1_q + {{(PROD_W-ICPT_W){icb_q[ICPT_W-1]}}, icb_q};
  assign ptr_next = {1'b0, ptr_q} + 1'b1;

  // operands of the shared multiplier pair
  always_comb begin
    if (item_q.command == CMD_ADD) begin
      op_a0 = $signed({rd_b.intercept[ICPT_W-1], rd_b.intercept})
            - $signed({rd_a.intercept[ICPT_W-1], rd_a.intercept});
      op_c0 = $signed({item_q.slope[SLOPE_W-1], item_q.slope})
            - $signed({rd_a.slope[SLOPE_W-1], rd_a.slope});
      op_a1 = $signed({rd_a.intercept[ICPT_W-1], rd_a.intercept})
            - $signed({item_q.intercept[ICPT_W-1], item_q.intercept});
      op_c1 = $signed({rd_a.slope[SLOPE_W-1], rd_a.slope})
            - $signed({rd_b.slope[SLOPE_W-1], rd_b.slope});
    end else begin
      op_a0 = $signed({{(ICPT_W+1-SLOPE_W){rd_a.slope[SLOPE_W-1]}}, rd_a.slope});
      op_a1 = $signed({{(ICPT_W+1-SLOPE_W){rd_b.slope[SLOPE_W-1]}}, rd_b.slope});
      op_c0 = $signed({{(SLOPE_W+1-X_W){item_q.query_x[X_W-1]}}, item_q.query_x});
      op_c1 = op_c0;
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    hull_len_d  = hull_len_q;
    qp_d        = qp_q;
    prod0_d     = prod0_q;
    prod1_d     = prod1_q;
    ica_d       = ica_q;
    icb_d       = icb_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    push        = 1'b0;
    fin         = 1'b0;
    fin_item    = '{status: ST_ADDED, min_value: '0, hull_size: hull_len_q};
    req         = '{wr_en: 1'b0, wr_addr: len_q[IDX_W-1:0],
                    wr_line: '{slope: item_q.slope, intercept: item_q.intercept},
                    rd_addr_a: ptr_q, rd_addr_b: IDX_W'(ptr_next)};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          len_d   = hull_len_q;
          ptr_d   = clamp_ptr;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (item_q.command == CMD_ADD) begin
          if (len_q > CNT_W'(1)) begin
            req.rd_addr_a = IDX_W'(len_q - CNT_W'(1));
            req.rd_addr_b = IDX_W'(len_q - CNT_W'(2));
            state_d       = S_MUL;
          end else begin
            push = 1'b1;
          end
        end else if (hull_len_q == '0) begin
          fin             = 1'b1;
          fin_item.status = ST_EMPTY;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod0_d = PROD_W'(op_a0) * PROD_W'(op_c0);
        prod1_d = PROD_W'(op_a1) * PROD_W'(op_c1);
        ica_d   = rd_a.intercept;
        icb_d   = rd_b.intercept;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (item_q.command == CMD_ADD) begin
          if (prod0_q >= prod1_q) begin
            // top line is useless: pop it and test the next pair
            len_d   = len_q - CNT_W'(1);
            state_d = S_READ;
          end else begin
            push = 1'b1;
          end
        end else if ((ptr_next < hull_len_q) && (val_b <= val_a)) begin
          ptr_d   = IDX_W'(ptr_next);
          state_d = S_READ;
        end else begin
          qp_d               = ptr_q;
          fin                = 1'b1;
          fin_item.status    = ST_ANSWER;
          fin_item.min_value = val_a[VAL_W-1:0];
        end
      end
      S_WAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // push lands before the next read of the store
    if (push) begin
      fin = 1'b1;
      if (len_q < MAX_CNT) begin
        req.wr_en       = 1'b1;
        hull_len_d      = len_q + CNT_W'(1);
        fin_item.status = ST_ADDED;
      end else begin
        fin_item.status = ST_FULL;
      end
    end

    if (fin) begin
      fin_item.hull_size = hull_len_d;
      if (out_free) begin
        out_valid_d = 1'b1;
        out_item_d  = fin_item;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_item;
        state_d = S_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hull_len_q  <= '0;
      qp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hull_len_q  <= hull_len_d;
      qp_q        <= qp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    len_q      <= len_d;
    ptr_q      <= ptr_d;
    prod0_q    <= prod0_d;
    prod1_q    <= prod1_d;
    ica_q      <= ica_d;
    icb_q      <= icb_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/core/mlemq_store.sv]
// Line store of the hull: one write port, two registered read ports.
module mlemq_store (
  input  logic                   clk_i,
  input  mlemq_pkg::store_req_t  req_i,
  output mlemq_pkg::line_t       rd_a_o,
  output mlemq_pkg::line_t       rd_b_o
);
  import mlemq_pkg::*;

  line_t mem_q [MAX_LINES];
  line_t rd_a_q;
  line_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_line;
    end
    rd_a_q <= mem_q[req_i.rd_addr_a];
    rd_b_q <= mem_q[req_i.rd_addr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

[rtl/core/mlemq_checker.sv]
// Port-level checks of the lower envelope unit, bound to the top level.
module mlemq_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input mlemq_pkg::out_item_t  out_item_o
);
  import mlemq_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_ANSWER) |-> out_item_o.min_value == '0)
    else $error("nonzero value without an answered query");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.hull_size <= MAX_CNT)
    else $error("hull size beyond capacity");

  a_size_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_item_o.status == ST_EMPTY) && (out_item_o.hull_size == '0)) ||
      ((out_item_o.status == ST_FULL) && (out_item_o.hull_size == MAX_CNT)) ||
      ((out_item_o.status == ST_ADDED) && (out_item_o.hull_size != '0)) ||
      ((out_item_o.status == ST_ANSWER) && (out_item_o.hull_size != '0)))
    else $error("status does not match hull size");

endmodule

bind monotone_lower_envelope_min_query_unit mlemq_checker u_mlemq_checker (.*);
